// File: rtl/rbp_pkg.sv
// Package for the random bisection pairing unit.
// Holds the sizes, register indexes and result codes shared by the RTL files.
// Depends on nothing.
package rbp_pkg;

    // Largest number of ranks that can be paired (2 to 32).
    localparam int MAX_RANKS  = 32;
    // Width of an internal rank, position or table entry.
    localparam int RANK_W     = $clog2(MAX_RANKS);
    // Width of a count that can hold MAX_RANKS itself.
    localparam int CNT_W      = RANK_W + 1;

    // Fixed field widths of the channels.
    localparam int DRAW_W     = 5;
    localparam int RANK_OUT_W = 5;
    localparam int CMP_W      = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_RANK_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC_MODE = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RANK_COUNT_RESET  = 6'd32;

    // Result codes.
    localparam logic OP_SEND         = 1'b0;
    localparam logic OP_RECV         = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_DRAW = 1'b1;

endpackage

// File: rtl/random_bisection_pairing_unit.sv
// Top level of the random bisection pairing unit.
// Holds the draw sequencer, the used marks, the permutation tables and the result register.
// Depends on rbp_pkg.

// The unit builds a random permutation of n ranks, where n is rank_count saturated to
// MAX_RANKS and rounded down to even, and pairs the ranks into a bisection. Each accepted
// draw item k selects the k-th still-unused position. A single scan counter walks the used
// marks one position per cycle, up to and including the chosen one, and in_stall is high
// meanwhile. A draw that is not below the remaining count leaves the state alone and
// produces one result item with status set. The draw that completes the permutation then
// emits one result per rank in ascending order (two per rank in symmetric mode), one result
// item per cycle as long as out_stall stays low, with last_of_run on the final one; the used
// marks and the draw count are cleared in the same cycle that the last draw is recorded, so
// no clearing pass follows. Results leave through a single output register, so the unit can
// accept a new draw while an error result still waits. Writing rank_count restarts the
// pairing in progress; writing symmetric_mode takes effect at the next completion.
// Configuration must be written only while the unit is idle and no result item is still
// owed.
module random_bisection_pairing_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [rbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rbp_pkg::DRAW_W-1:0]     draw,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rbp_pkg::RANK_OUT_W-1:0] rank,
    output logic                          op_kind,
    output logic [rbp_pkg::RANK_OUT_W-1:0] partner,
    output logic                          status,
    output logic                          last_of_run
);
    import rbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ERR,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CFG_DATA_W-1:0]   rank_count_reg;
    logic                    symmetric_mode_reg;
    logic [MAX_RANKS-1:0]    used_reg;
    logic [CNT_W-1:0]        draw_count_reg;
    logic [RANK_W-1:0]       pos_reg;
    logic [RANK_W-1:0]       k_reg;
    logic [RANK_W-1:0]       r_reg;
    logic                    phase_reg;

    // Permutation and its inverse; entries are meaningful only once written.
    logic [RANK_W-1:0]       perm_table [MAX_RANKS];
    logic [RANK_W-1:0]       inverse_table [MAX_RANKS];

    logic                    out_valid_reg;
    logic [RANK_OUT_W-1:0]   rank_reg;
    logic                    op_kind_reg;
    logic [RANK_OUT_W-1:0]   partner_reg;
    logic                    status_reg;
    logic                    last_reg;

    logic [CNT_W-1:0]        active_n;
    logic [RANK_W-1:0]       half_span;
    logic [CNT_W-1:0]        remaining;
    logic                    draw_in_range;
    logic                    pos_avail;
    logic                    scan_hit;
    logic [CNT_W-1:0]        draw_count_next;
    logic                    pairing_done;
    logic [RANK_W-1:0]       inv_entry;
    logic                    is_sender;
    logic [RANK_W-1:0]       partner_idx;
    logic [RANK_W-1:0]       partner_rank;
    logic                    first_op;
    logic                    rank_is_last;
    logic                    out_free;
    logic                    load_out;

    always_comb
    begin
        // Saturate to MAX_RANKS, then round down to even.
        if (rank_count_reg > CFG_DATA_W'(MAX_RANKS))
        begin
            active_n = CNT_W'(MAX_RANKS) & ~CNT_W'(1);
        end
        else
        begin
            active_n = CNT_W'(rank_count_reg) & ~CNT_W'(1);
        end
        half_span = RANK_W'(active_n >> 1);

        remaining     = (draw_count_reg < active_n) ? active_n - draw_count_reg : '0;
        draw_in_range = CMP_W'(draw) < CMP_W'(remaining);

        pos_avail       = (CNT_W'(pos_reg) < active_n) && !used_reg[pos_reg];
        scan_hit        = (state_reg == ST_SCAN) && pos_avail && (k_reg == '0);
        draw_count_next = draw_count_reg + CNT_W'(1);
        pairing_done    = draw_count_next == active_n;

        // Partner lookup for the rank being emitted.
        inv_entry    = inverse_table[r_reg];
        is_sender    = inv_entry < half_span;
        partner_idx  = is_sender ? inv_entry + half_span : inv_entry - half_span;
        partner_rank = perm_table[partner_idx];
        first_op     = is_sender ? OP_SEND : OP_RECV;
        rank_is_last = (CNT_W'(r_reg) + CNT_W'(1)) == active_n;

        out_free = !out_valid_reg || !out_stall;
        // A new result item enters the output register this cycle.
        load_out = out_free && ((state_reg == ST_ERR) || (state_reg == ST_EMIT));
    end

    assign in_stall    = state_reg != ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign rank        = rank_reg;
    assign op_kind     = op_kind_reg;
    assign partner     = partner_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    // Table writes happen on the cycle the scan finds the chosen position.
    always_ff @(posedge clk)
    begin
        if (scan_hit)
        begin
            perm_table[draw_count_reg[RANK_W-1:0]] <= pos_reg;
            inverse_table[pos_reg]                 <= draw_count_reg[RANK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            rank_count_reg     <= RANK_COUNT_RESET;
            symmetric_mode_reg <= 1'b0;
            used_reg           <= '0;
            draw_count_reg     <= '0;
            pos_reg            <= '0;
            k_reg              <= '0;
            r_reg              <= '0;
            phase_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            rank_reg           <= '0;
            op_kind_reg        <= OP_SEND;
            partner_reg        <= '0;
            status_reg         <= STATUS_OK;
            last_reg           <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (draw_in_range)
                        begin
                            k_reg     <= RANK_W'(draw);
                            pos_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_ERR;
                        end
                    end
                end

                ST_ERR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        rank_reg      <= '0;
                        op_kind_reg   <= OP_SEND;
                        partner_reg   <= '0;
                        status_reg    <= STATUS_BAD_DRAW;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_SCAN:
                begin
                    pos_reg <= pos_reg + RANK_W'(1);
                    if (pos_avail)
                    begin
                        if (k_reg == '0)
                        begin
                            if (pairing_done)
                            begin
                                // Permutation complete: clear for the next pairing now.
                                used_reg       <= '0;
                                draw_count_reg <= '0;
                                r_reg          <= '0;
                                phase_reg      <= 1'b0;
                                state_reg      <= ST_EMIT;
                            end
                            else
                            begin
                                used_reg[pos_reg] <= 1'b1;
                                draw_count_reg    <= draw_count_next;
                                state_reg         <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg - RANK_W'(1);
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        rank_reg      <= RANK_OUT_W'(r_reg);
                        op_kind_reg   <= phase_reg ? ~first_op : first_op;
                        partner_reg   <= RANK_OUT_W'(partner_rank);
                        status_reg    <= STATUS_OK;
                        last_reg      <= rank_is_last && (phase_reg || !symmetric_mode_reg);
                        if (symmetric_mode_reg && !phase_reg)
                        begin
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            phase_reg <= 1'b0;
                            r_reg     <= r_reg + RANK_W'(1);
                            if (rank_is_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Users write configuration only in idle (unchecked); count writes restart pairing.
            if (cfg_write_en)
            begin
                if (cfg_index == REG_RANK_COUNT)
                begin
                    rank_count_reg <= cfg_data;
                    used_reg       <= '0;
                    draw_count_reg <= '0;
                end
                else if (cfg_index == REG_SYMMETRIC_MODE)
                begin
                    symmetric_mode_reg <= cfg_data[0];
                end
            end
        end
    end

endmodule

// File: rtl/rbp_checker.sv
// Port-level checker for the random bisection pairing unit, and its bind statement.
// Depends on rbp_pkg and on the port list of random_bisection_pairing_unit.
module rbp_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [rbp_pkg::RANK_OUT_W-1:0] rank,
    input  logic                          op_kind,
    input  logic [rbp_pkg::RANK_OUT_W-1:0] partner,
    input  logic                          status,
    input  logic                          last_of_run
);
    import rbp_pkg::*;

    // Every accepted item keeps the unit busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("unit took a second item right after the first");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rank) && $stable(partner)
            && $stable(op_kind) && $stable(status) && $stable(last_of_run)))
        else $error("stalled result item changed");

    // An error result is a single, empty item.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_BAD_DRAW) |->
            (last_of_run && rank == '0 && partner == '0 && op_kind == OP_SEND))
        else $error("malformed out-of-range result");

    // A pairing never pairs a rank with itself.
    a_no_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |-> (partner != rank))
        else $error("rank paired with itself");

endmodule

bind random_bisection_pairing_unit rbp_checker u_rbp_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for random_bisection_pairing_unit.
// Drives draw items and register writes, and checks every result item against a predictor.
// Depends on rbp_pkg and the RTL of the unit.

module tb;
    import rbp_pkg::*;

    // Result item as it leaves the unit, in port order.
    typedef struct packed {
        logic [RANK_OUT_W-1:0] rank;
        logic                  kind;
        logic [RANK_OUT_W-1:0] partner;
        logic                  status;
        logic                  last_flag;
    } pairing_op_t;

    // A row of the directed table is either a draw item or a register write.
    typedef enum logic {ROW_DRAW, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        pairing_op_t            want;
    } script_row_t;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam pairing_op_t BAD_DRAW = '{5'd0, OP_SEND, 5'd0, STATUS_BAD_DRAW, 1'b1};
    localparam pairing_op_t NO_OP    = '0;

    // A draw scans at most MAX_RANKS positions, so this covers the unit's own work
    // after the last expected result item with room to spare.
    localparam int DRAIN_CYCLES  = 2 * MAX_RANKS + 8;
    localparam int RANDOM_DRAWS  = 500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SCRIPT_LEN    = 26;
    localparam int SHOWN_FAULTS  = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [DRAW_W-1:0]     draw;
    logic                  out_valid;
    logic                  out_stall;
    logic [RANK_OUT_W-1:0] rank;
    logic                  op_kind;
    logic [RANK_OUT_W-1:0] partner;
    logic                  status;
    logic                  last_of_run;

    random_bisection_pairing_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .draw        (draw),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rank        (rank),
        .op_kind     (op_kind),
        .partner     (partner),
        .status      (status),
        .last_of_run (last_of_run)
    );

    // Predictor state: the registers and the partial permutation as the unit should hold them.
    logic [CFG_DATA_W-1:0] ranks_cfg;
    logic                  both_ways;
    logic [MAX_RANKS-1:0]  marks_q;
    logic [RANK_W-1:0]     perm_q [MAX_RANKS];
    logic [RANK_W-1:0]     slot_of_q [MAX_RANKS];
    int                    taken_q;

    // Result items still owed by the unit, oldest first.
    pairing_op_t pending_ops [$];

    int  bad_count = 0;
    int  cycle_count = 0;
    // While set, neither side idles; this gives the long stretch at full rate.
    bit  steady;

    // The directed part. Error results are typed in; everything else comes from the
    // predictor. Comments name the case that each group of rows covers.
    script_row_t script [0:SCRIPT_LEN-1] = '{
        // Largest draw value as the first draw of the reset pairing of 32 ranks.
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd31, 1'b0, NO_OP},
        // Zero ranks: every draw is out of range, the extremes included.
        '{ROW_WRITE, REG_RANK_COUNT,     6'd0,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b1, BAD_DRAW},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd31, 1'b1, BAD_DRAW},
        // Two ranks: an in-range draw between two at the remaining count, then completion.
        '{ROW_WRITE, REG_RANK_COUNT,     6'd2,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd2,  1'b1, BAD_DRAW},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd1,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd1,  1'b1, BAD_DRAW},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b0, NO_OP},
        // Symmetric mode with an odd count that rounds down to two ranks.
        '{ROW_WRITE, REG_SYMMETRIC_MODE, 6'd1,  1'b0, NO_OP},
        '{ROW_WRITE, REG_RANK_COUNT,     6'd3,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b0, NO_OP},
        // A count of one rounds down to zero ranks.
        '{ROW_WRITE, REG_RANK_COUNT,     6'd1,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd16, 1'b1, BAD_DRAW},
        // Oversized count saturates to the full rank set.
        '{ROW_WRITE, REG_RANK_COUNT,     6'd63, 1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd31, 1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd31, 1'b1, BAD_DRAW},
        // A count rewrite restarts the pairing; spare indexes and a mode rewrite in the
        // middle of a pairing must not.
        '{ROW_WRITE, REG_RANK_COUNT,     6'd4,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd3,  1'b0, NO_OP},
        '{ROW_WRITE, REG_SPARE_2,        6'd63, 1'b0, NO_OP},
        '{ROW_WRITE, REG_SPARE_3,        6'd0,  1'b0, NO_OP},
        '{ROW_WRITE, REG_SYMMETRIC_MODE, 6'd0,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd1,  1'b0, NO_OP},
        '{ROW_DRAW,  REG_RANK_COUNT,     6'd0,  1'b0, NO_OP}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Number of ranks in play: the count saturates first, then drops to even.
    function automatic int active_ranks();
        int n;
        n = (ranks_cfg > MAX_RANKS) ? MAX_RANKS : int'(ranks_cfg);
        return n & ~1;
    endfunction

    function automatic int ranks_left();
        int n;
        n = active_ranks();
        return (taken_q < n) ? n - taken_q : 0;
    endfunction

    // Applies one accepted draw to the predictor and queues the result items it causes.
    function automatic void advance_pairing(input logic [DRAW_W-1:0] d);
        int          n;
        int          k;
        int          pick;
        int          p;
        int          r;
        int          half;
        int          i;
        int          total;
        int          emitted;
        bit          found;
        bit          sender;
        pairing_op_t op;
        n = active_ranks();
        if (int'(d) >= ranks_left())
        begin
            pending_ops.push_back(BAD_DRAW);
            return;
        end
        // Walk the unused positions in ascending order until the k-th one.
        k = int'(d);
        pick = 0;
        found = 1'b0;
        for (p = 0; p < MAX_RANKS; p++)
        begin
            if (!found && p < n && !marks_q[p])
            begin
                if (k == 0)
                begin
                    pick = p;
                    found = 1'b1;
                end
                else
                begin
                    k--;
                end
            end
        end
        marks_q[pick] = 1'b1;
        perm_q[taken_q] = RANK_W'(pick);
        slot_of_q[pick] = RANK_W'(taken_q);
        taken_q++;
        if (taken_q < n)
            return;
        // The permutation is complete: the first half of it pairs with the second half.
        half = n / 2;
        total = both_ways ? 2 * n : n;
        emitted = 0;
        for (r = 0; r < n; r++)
        begin
            i = int'(slot_of_q[r]);
            sender = (i < half);
            op.rank = RANK_OUT_W'(r);
            op.kind = sender ? OP_SEND : OP_RECV;
            op.partner = perm_q[sender ? i + half : i - half];
            op.status = STATUS_OK;
            op.last_flag = (emitted == total - 1);
            pending_ops.push_back(op);
            emitted++;
            if (both_ways)
            begin
                op.kind = ~op.kind;
                op.last_flag = (emitted == total - 1);
                pending_ops.push_back(op);
                emitted++;
            end
        end
        marks_q = '0;
        taken_q = 0;
    endfunction

    function automatic void flag_op(input string what, input pairing_op_t want,
                                    input pairing_op_t got);
        bad_count++;
        if (bad_count <= SHOWN_FAULTS)
        begin
            $display("%s: got rank %0d kind %0d partner %0d status %0d last %0d",
                     what, got.rank, got.kind, got.partner, got.status, got.last_flag);
            $display("    expected rank %0d kind %0d partner %0d status %0d last %0d",
                     want.rank, want.kind, want.partner, want.status, want.last_flag);
        end
    endfunction

    // Offers one draw item and returns at the rising edge where the unit takes it.
    // A random number of idle cycles may come first.
    task automatic offer_draw(input logic [DRAW_W-1:0] d);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        draw = d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Brings the unit to rest: no draw offered, every owed result item received, and
    // enough extra cycles for a draw that causes no result to finish its scan.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_ops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        if (idx == REG_RANK_COUNT)
        begin
            ranks_cfg = value;
            marks_q = '0;
            taken_q = 0;
        end
        else if (idx == REG_SYMMETRIC_MODE)
        begin
            both_ways = value[0];
        end
    endtask

    // Output side: random stall, except during the steady stretch.
    always @(negedge clk)
    begin
        out_stall = rst_n && !steady && ($urandom_range(0, 99) < 9);
    end

    // Result checker: each accepted result item is held against the oldest expectation.
    always @(posedge clk)
    begin
        pairing_op_t got;
        pairing_op_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {rank, op_kind, partner, status, last_of_run};
            if (pending_ops.size() == 0)
            begin
                flag_op("result item with nothing expected", NO_OP, got);
            end
            else
            begin
                want = pending_ops.pop_front();
                if (got.rank !== want.rank || got.kind !== want.kind ||
                    got.partner !== want.partner || got.status !== want.status ||
                    got.last_flag !== want.last_flag)
                    flag_op("result item mismatch", want, got);
            end
        end
    end

    // Watchdog: a run that hangs waiting for an item or a result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int                    row;
        int                    base;
        int                    valid_draws;
        int                    phase_len;
        int                    j;
        int                    n;
        int                    pick;
        int                    left;
        logic [DRAW_W-1:0]     d;
        logic [CFG_DATA_W-1:0] count_value;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_RANK_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        draw = '0;
        steady = 1'b0;
        ranks_cfg = RANK_COUNT_RESET;
        both_ways = 1'b0;
        marks_q = '0;
        taken_q = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A typed row still runs the predictor so that its state follows
        // the unit, but the typed result item takes the place of the predicted one.
        for (row = 0; row < SCRIPT_LEN; row++)
        begin
            if (script[row].kind == ROW_WRITE)
            begin
                settle();
                write_reg(script[row].idx, script[row].value);
            end
            else
            begin
                offer_draw(script[row].value[DRAW_W-1:0]);
                base = pending_ops.size();
                advance_pairing(script[row].value[DRAW_W-1:0]);
                if (script[row].typed)
                begin
                    while (pending_ops.size() > base)
                        void'(pending_ops.pop_back());
                    pending_ops.push_back(script[row].want);
                end
            end
        end

        // Random part, in phases. Each phase sets up the registers and then mostly plays
        // draws that are in range, so pairings complete often; a few draws are noise over
        // the whole field and usually land out of range. A phase ends at an arbitrary
        // point, so the next count write often restarts a pairing in progress.
        valid_draws = 0;
        while (valid_draws < RANDOM_DRAWS)
        begin
            settle();
            if ($urandom_range(0, 99) < 80)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    count_value = CFG_DATA_W'($urandom_range(0, 1));
                else if (pick < 12)
                    count_value = CFG_DATA_W'($urandom_range(32, 63));
                else if (pick < 20)
                    count_value = CFG_DATA_W'(2 * $urandom_range(1, 7) + 1);
                else
                    count_value = CFG_DATA_W'(2 * $urandom_range(1, 4));
                write_reg(REG_RANK_COUNT, count_value);
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_SYMMETRIC_MODE, CFG_DATA_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 99) < 5)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom_range(0, 63)));

            n = active_ranks();
            phase_len = (n == 0) ? 3 : n * $urandom_range(1, 3) + $urandom_range(0, n);
            for (j = 0; j < phase_len && valid_draws < RANDOM_DRAWS; j++)
            begin
                left = ranks_left();
                if (left > 0 && $urandom_range(0, 99) >= 8)
                    d = DRAW_W'($urandom_range(0, left - 1));
                else
                    d = DRAW_W'($urandom_range(0, 31));
                if (int'(d) < left)
                    valid_draws++;
                steady = (valid_draws >= 200 && valid_draws < 320);
                offer_draw(d);
                advance_pairing(d);
            end
        end
        steady = 1'b0;

        // Wait for the last owed result item, then watch a while for strays.
        settle();
        if (bad_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rbp_pkg.sv
rtl/random_bisection_pairing_unit.sv
rtl/rbp_checker.sv
tb/tb.sv
